// ----- design/wav_header_parser_core_defines.svh -----
// Assertion macros for the checker file of the WAV header parser.
`ifndef WAV_HEADER_PARSER_CORE_DEFINES_SVH
`define WAV_HEADER_PARSER_CORE_DEFINES_SVH

// Concurrent assertion sampled on clock, off while reset is high.
`define WAVH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication form: whenever cond holds, expr must hold in the same cycle.
`define WAVH_ASSERT_IMP(label, cond, expr, msg) \
   `WAVH_ASSERT(label, (cond) |-> (expr), msg)

`endif

// ----- design/wavh_pkg.sv -----
// Shared types and constants of the WAV header parser.
package wavh_pkg;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_UNSUP = 2'd3;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
   localparam logic [15:0] FORMAT_PCM   = 16'd1;
   localparam logic [31:0] LEN_UNKNOWN  = 32'hffff_ffff;

   localparam logic [5:0] POS_RIFF     = 6'd3;
   localparam logic [5:0] POS_WAVE     = 6'd11;
   localparam logic [5:0] POS_FMT      = 6'd15;
   localparam logic [5:0] POS_FMT_SIZE = 6'd19;
   localparam logic [5:0] POS_FORMAT   = 6'd21;
   localparam logic [5:0] POS_CHANNELS = 6'd23;
   localparam logic [5:0] POS_RATE     = 6'd27;
   localparam logic [5:0] POS_ALIGN    = 6'd33;
   localparam logic [5:0] POS_BITS     = 6'd35;
   localparam logic [5:0] POS_DATA     = 6'd39;
   localparam logic [5:0] POS_LAST     = 6'd43;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int DIV_STEPS = 32;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] align;
      logic [15:0] bits;
      logic [31:0] length;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

endpackage

// ----- design/wavh_ifs.sv -----
// Request and response channel interfaces of the WAV header parser.
interface wavh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       stream_end;

   modport source (output valid, header_byte, stream_end, input ready);
   modport sink (input valid, header_byte, stream_end, output ready);
   modport monitor (input valid, ready, header_byte, stream_end);
endinterface

interface wavh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] channel_count;
   logic [31:0] rate_hz;
   logic [15:0] frame_bytes;
   logic [15:0] sample_bits;
   logic [31:0] payload_bytes;
   logic [31:0] frame_count;

   modport source (output valid, status, channel_count, rate_hz, frame_bytes,
                   sample_bits, payload_bytes, frame_count, input ready);
   modport sink (input valid, status, channel_count, rate_hz, frame_bytes,
                 sample_bits, payload_bytes, frame_count, output ready);
   modport monitor (input valid, ready, status, channel_count, rate_hz, frame_bytes,
                    sample_bits, payload_bytes, frame_count);
endinterface

// ----- design/wavh_front.sv -----
// Front end: byte intake, tag and field checks, field capture.
module wavh_front
   import wavh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  logic [7:0] in_byte,
   input  logic     in_end,
   input  logic     room,
   output logic     in_ready,
   output push_type push
);

   logic [5:0]  pos_ff, pos_in;
   logic [1:0]  err_ff, err_in;
   logic [31:0] scratch_ff, scratch_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic        take;
   logic [31:0] word;
   logic [15:0] hi16;
   logic        fail;
   logic [1:0]  code;
   logic [1:0]  err_next;

   assign in_ready = room;
   assign take     = in_valid && room;
   assign word     = {in_byte, scratch_ff[31:8]};
   assign hi16     = word[31:16];

   always_comb begin
      fail        = 1'b0;
      code        = ST_BAD;
      channels_in = channels_ff;
      rate_in     = rate_ff;
      align_in    = align_ff;
      bits_in     = bits_ff;
      case (pos_ff)
         POS_RIFF: fail = (word != TAG_RIFF);
         POS_WAVE: fail = (word != TAG_WAVE);
         POS_FMT:  fail = (word != TAG_FMT);
         POS_FMT_SIZE: begin
            fail = (word != FMT_SIZE_PCM);
            code = ST_UNSUP;
         end
         POS_FORMAT: begin
            fail = (hi16 != FORMAT_PCM);
            code = ST_UNSUP;
         end
         POS_CHANNELS: begin
            channels_in = hi16;
            fail        = (hi16 == 16'd0);
         end
         POS_RATE: begin
            rate_in = word;
            fail    = (word == 32'd0);
         end
         POS_ALIGN: align_in = hi16;
         POS_BITS:  bits_in = hi16;
         POS_DATA:  fail = (word != TAG_DATA);
         POS_LAST:  fail = (word != LEN_UNKNOWN) && (align_ff == 16'd0);
         default: ;
      endcase
      err_next = (err_ff == ST_OK && fail) ? code : err_ff;
   end

   always_comb begin
      push.valid         = 1'b0;
      push.job.status    = err_next;
      push.job.channels  = channels_ff;
      push.job.rate      = rate_ff;
      push.job.align     = align_ff;
      push.job.bits      = bits_ff;
      push.job.length    = word;
      pos_in             = pos_ff;
      err_in             = err_ff;
      scratch_in         = scratch_ff;
      if (take) begin
         if (in_end) begin
            push.valid      = 1'b1;
            push.job.status = ST_SHORT;
            pos_in          = 6'd0;
            err_in          = ST_OK;
         end else if (pos_ff == POS_LAST) begin
            push.valid = 1'b1;
            pos_in     = 6'd0;
            err_in     = ST_OK;
         end else begin
            pos_in     = pos_ff + 6'd1;
            err_in     = err_next;
            scratch_in = word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
         err_ff <= ST_OK;
      end else begin
         pos_ff <= pos_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      scratch_ff <= scratch_in;
      if (take && !in_end) begin
         channels_ff <= channels_in;
         rate_ff     <= rate_in;
         align_ff    <= align_in;
         bits_ff     <= bits_in;
      end
   end

endmodule

// ----- design/wavh_queue.sv -----
// Short job queue between the front and back ends.
module wavh_queue
   import wavh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   input  logic     pop,
   output logic     avail,
   output job_type  head
);

   job_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wptr_ff, rptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign room    = (count_ff != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign avail   = (count_ff != '0);
   assign head    = mem[rptr_ff];
   assign do_push = push.valid && room;
   assign do_pop  = pop && avail;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wptr_ff <= (wptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= push.job;
      end
   end

endmodule

// ----- design/wavh_back.sv -----
// Back end: serial frame-count divider, divisibility check, response register.
module wavh_back
   import wavh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    avail,
   input  job_type head,
   output logic    pop,
   wavh_rsp_if.source rsp_bus
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0]        state_ff, state_in;
   job_type           job_ff;
   logic [15:0]       rem_ff, rem_in;
   logic [31:0]       quo_ff, quo_in;
   logic [DIV_CW-1:0] cnt_ff;
   logic [16:0]       trial;
   logic              ge;
   logic              known;
   logic              need_div;
   logic              out_free;
   logic [1:0]        fin_status;
   logic              rsp_valid_ff;
   logic [1:0]        status_ff;
   logic [15:0]       channels_ff, align_ff, bits_ff;
   logic [31:0]       rate_ff, length_ff, count_ff;

   assign need_div = (head.status == ST_OK) && (head.length != LEN_UNKNOWN);
   assign known    = (job_ff.length != LEN_UNKNOWN);
   assign trial    = {rem_ff, quo_ff[31]};
   assign ge       = (trial >= {1'b0, job_ff.align});
   assign rem_in   = ge ? 16'(trial - {1'b0, job_ff.align}) : trial[15:0];
   assign quo_in   = {quo_ff[30:0], ge};
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign pop      = (state_ff == S_IDLE) && avail;

   always_comb begin
      fin_status = job_ff.status;
      if (job_ff.status == ST_OK && known && rem_ff != 16'd0) begin
         fin_status = ST_BAD;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (avail) state_in = need_div ? S_DIV : S_LOAD;
         S_DIV:  if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) state_in = S_LOAD;
         S_LOAD: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_LOAD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head;
         rem_ff <= 16'd0;
         quo_ff <= head.length;
         cnt_ff <= '0;
      end else if (state_ff == S_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == S_LOAD && out_free) begin
         status_ff <= fin_status;
         if (fin_status == ST_OK) begin
            channels_ff <= job_ff.channels;
            rate_ff     <= job_ff.rate;
            align_ff    <= job_ff.align;
            bits_ff     <= job_ff.bits;
            length_ff   <= job_ff.length;
            count_ff    <= known ? quo_ff : LEN_UNKNOWN;
         end else begin
            channels_ff <= 16'd0;
            rate_ff     <= 32'd0;
            align_ff    <= 16'd0;
            bits_ff     <= 16'd0;
            length_ff   <= 32'd0;
            count_ff    <= 32'd0;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.channel_count = channels_ff;
   assign rsp_bus.rate_hz       = rate_ff;
   assign rsp_bus.frame_bytes   = align_ff;
   assign rsp_bus.sample_bits   = bits_ff;
   assign rsp_bus.payload_bytes = length_ff;
   assign rsp_bus.frame_count   = count_ff;

endmodule

// ----- design/wav_header_parser_core.sv -----
// Canonical 44-byte RIFF/WAVE PCM header parser: one request per header byte or
// end marker, one response per header. Header bytes are taken one per cycle while
// the queue has room; a header costs 44 requests, an early end marker closes it at
// once with a short status. The front end checks tags and fields as bytes arrive
// and hands each finished header to a two-entry queue. The back end works out the
// frame count with a one-bit-per-cycle divider: a header with an ok status and a
// known data length passes through the divider, any other goes straight to the
// response register. Since the back end is faster than a full header, bytes stream
// without a gap; req_bus.ready drops only while both queue entries wait, which
// takes a run of end markers or a stalled response channel.
module wav_header_parser_core
   import wavh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wavh_req_if.sink   req_bus,
   wavh_rsp_if.source rsp_bus
);

   push_type push;
   logic     room;
   logic     avail;
   logic     pop;
   job_type  head;

   wavh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_byte  (req_bus.header_byte),
      .in_end   (req_bus.stream_end),
      .room     (room),
      .in_ready (req_bus.ready),
      .push     (push)
   );

   wavh_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .room  (room),
      .pop   (pop),
      .avail (avail),
      .head  (head)
   );

   wavh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .avail   (avail),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- design/wavh_checker.sv -----
// Port-level assertions for the WAV header parser and their bind.
`include "wav_header_parser_core_defines.svh"

module wavh_checker
   import wavh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_channel_count,
   input logic [31:0] rsp_rate_hz,
   input logic [15:0] rsp_frame_bytes,
   input logic [15:0] rsp_sample_bits,
   input logic [31:0] rsp_payload_bytes,
   input logic [31:0] rsp_frame_count
);

   logic         stalled;
   logic         is_error;
   logic         is_ok;
   logic         unknown_len;
   logic         count_unknown;
   logic         fields_zero;
   logic         fields_set;
   logic [145:0] rsp_word;

   assign stalled       = rsp_valid && !rsp_ready;
   assign is_error      = rsp_valid && (rsp_status != ST_OK);
   assign is_ok         = rsp_valid && (rsp_status == ST_OK);
   assign unknown_len   = (rsp_payload_bytes == LEN_UNKNOWN);
   assign count_unknown = (rsp_frame_count == LEN_UNKNOWN);
   assign fields_zero   = (rsp_channel_count == 16'd0) && (rsp_rate_hz == 32'd0) &&
                          (rsp_frame_bytes == 16'd0) && (rsp_sample_bits == 16'd0) &&
                          (rsp_payload_bytes == 32'd0) && (rsp_frame_count == 32'd0);
   assign fields_set    = (rsp_channel_count != 16'd0) && (rsp_rate_hz != 32'd0) &&
                          (unknown_len || rsp_frame_bytes != 16'd0);
   assign rsp_word      = {rsp_status, rsp_channel_count, rsp_rate_hz, rsp_frame_bytes,
                           rsp_sample_bits, rsp_payload_bytes, rsp_frame_count};

   `WAVH_ASSERT(a_rsp_hold, stalled |=> rsp_valid && $stable(rsp_word), "response not held")
   `WAVH_ASSERT_IMP(a_err_zero, is_error, fields_zero, "error response with nonzero fields")
   `WAVH_ASSERT_IMP(a_unknown_len, is_ok && unknown_len, count_unknown, "bad streaming count")
   `WAVH_ASSERT_IMP(a_ok_fields, is_ok, fields_set, "ok response with a zero field")

endmodule

bind wav_header_parser_core wavh_checker u_wavh_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_channel_count (rsp_bus.channel_count),
   .rsp_rate_hz       (rsp_bus.rate_hz),
   .rsp_frame_bytes   (rsp_bus.frame_bytes),
   .rsp_sample_bits   (rsp_bus.sample_bits),
   .rsp_payload_bytes (rsp_bus.payload_bytes),
   .rsp_frame_count   (rsp_bus.frame_count)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the WAV header parser core: byte stream in, header summary out.
`timescale 1ns / 1ps

module testbench
   import wavh_pkg::*;
();

   typedef struct packed {
      logic [7:0] header_byte;
      logic       stream_end;
      logic       drain;
      logic [7:0] gap_after;
   } pending_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] channel_count;
      logic [31:0] rate_hz;
      logic [15:0] frame_bytes;
      logic [15:0] sample_bits;
      logic [31:0] payload_bytes;
      logic [31:0] frame_count;
   } header_summary_type;

   logic clock;
   logic reset;

   wavh_req_if req_bus ();
   wavh_rsp_if rsp_bus ();

   wav_header_parser_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pending_request_type pending_requests[$];
   header_summary_type  expected_headers[$];
   logic [7:0]          hdr_image [0:43];

   int fail_count;
   int request_total;
   int send_gap;
   int rsp_stall;
   int rsp_burst_left;
   bit burst_gaps;
   pending_request_type next_req;

   // parser shadow state
   logic [5:0]  parse_pos;
   logic [1:0]  parse_error;
   logic [31:0] shift_word;
   logic [15:0] seen_channels;
   logic [31:0] seen_rate;
   logic [15:0] seen_align;
   logic [15:0] seen_bits;
   logic [31:0] seen_length;

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 100);
   endfunction

   task automatic clear_parser();
      parse_pos     = '0;
      parse_error   = ST_OK;
      shift_word    = '0;
      seen_channels = '0;
      seen_rate     = '0;
      seen_align    = '0;
      seen_bits     = '0;
      seen_length   = '0;
   endtask

   task automatic raise_error(input logic [1:0] code);
      if (parse_error == ST_OK)
         parse_error = code;
   endtask

   task automatic predict_header_byte(input logic [7:0] b, input logic fin,
                                      output bit done, output header_summary_type s);
      logic [31:0] w;
      logic [1:0]  code;
      done = 1'b0;
      s    = '0;
      code = ST_OK;
      if (fin) begin
         done = 1'b1;
         code = ST_SHORT;
      end else begin
         w = {b, shift_word[31:8]};
         shift_word = w;
         case (parse_pos)
            POS_RIFF: if (w != TAG_RIFF) raise_error(ST_BAD);
            POS_WAVE: if (w != TAG_WAVE) raise_error(ST_BAD);
            POS_FMT: if (w != TAG_FMT) raise_error(ST_BAD);
            POS_FMT_SIZE: if (w != FMT_SIZE_PCM) raise_error(ST_UNSUP);
            POS_FORMAT: if (w[31:16] != FORMAT_PCM) raise_error(ST_UNSUP);
            POS_CHANNELS: begin
               seen_channels = w[31:16];
               if (w[31:16] == 16'd0) raise_error(ST_BAD);
            end
            POS_RATE: begin
               seen_rate = w;
               if (w == 32'd0) raise_error(ST_BAD);
            end
            POS_ALIGN: seen_align = w[31:16];
            POS_BITS: seen_bits = w[31:16];
            POS_DATA: if (w != TAG_DATA) raise_error(ST_BAD);
            POS_LAST: begin
               seen_length = w;
               if (w != LEN_UNKNOWN) begin
                  if (seen_align == 16'd0 || (w % {16'd0, seen_align}) != 32'd0)
                     raise_error(ST_BAD);
               end
            end
            default: ;
         endcase
         if (parse_pos == POS_LAST) begin
            done = 1'b1;
            code = parse_error;
         end else begin
            parse_pos = parse_pos + 6'd1;
         end
      end
      if (done) begin
         s.status = code;
         if (code == ST_OK) begin
            s.channel_count = seen_channels;
            s.rate_hz       = seen_rate;
            s.frame_bytes   = seen_align;
            s.sample_bits   = seen_bits;
            s.payload_bytes = seen_length;
            if (seen_length == LEN_UNKNOWN)
               s.frame_count = LEN_UNKNOWN;
            else if (seen_align != 16'd0)
               s.frame_count = seen_length / {16'd0, seen_align};
            else
               s.frame_count = '0;
         end
         clear_parser();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   task automatic queue_request(input logic [7:0] b, input logic fin, input logic drain);
      pending_request_type r;
      r.header_byte = b;
      r.stream_end  = fin;
      r.drain       = drain;
      r.gap_after   = burst_gaps ? 8'd0 : 8'(draw_gap());
      pending_requests.push_back(r);
      request_total++;
   endtask

   task automatic put_word(input int at, input logic [31:0] w);
      for (int k = 0; k < 4; k++)
         hdr_image[at + k] = w[8*k +: 8];
   endtask

   task automatic put_half(input int at, input logic [15:0] h);
      hdr_image[at]     = h[7:0];
      hdr_image[at + 1] = h[15:8];
   endtask

   task automatic make_header(input logic [15:0] ch, input logic [31:0] rate,
                              input logic [15:0] align, input logic [15:0] bits,
                              input logic [31:0] len);
      put_word(0, TAG_RIFF);
      put_word(4, $urandom);
      put_word(8, TAG_WAVE);
      put_word(12, TAG_FMT);
      put_word(16, FMT_SIZE_PCM);
      put_half(20, FORMAT_PCM);
      put_half(22, ch);
      put_word(24, rate);
      put_word(28, $urandom);
      put_half(32, align);
      put_half(34, bits);
      put_word(36, TAG_DATA);
      put_word(40, len);
   endtask

   task automatic queue_header(input int keep, input bit fin_after, input bit drain_first);
      for (int i = 0; i < keep; i++)
         queue_request(hdr_image[i], 1'b0, drain_first && i == 0);
      if (fin_after)
         queue_request(8'($urandom), 1'b1, drain_first && keep == 0);
   endtask

   task automatic queue_random_header();
      logic [15:0] ch;
      logic [15:0] align;
      logic [15:0] bits;
      logic [31:0] rate;
      logic [31:0] len;
      logic [31:0] kmax;
      logic [31:0] k;
      int          r;
      int          spot;
      burst_gaps = ($urandom_range(0, 3) == 0);
      ch = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(1, 8))
                                          : 16'($urandom_range(1, 16'hffff));
      case ($urandom_range(0, 4))
         0: bits = 16'd8;
         1: bits = 16'd16;
         2: bits = 16'd24;
         3: bits = 16'd32;
         default: bits = 16'($urandom);
      endcase
      r = $urandom_range(0, 99);
      if (r < 75)
         align = ch * bits / 16'd8;
      else if (r < 95)
         align = 16'($urandom);
      else
         align = 16'd0;
      case ($urandom_range(0, 4))
         0: rate = 32'd8000;
         1: rate = 32'd44100;
         2: rate = 32'd48000;
         3: rate = 32'd96000;
         default: rate = $urandom_range(1, 32'hffff_ffff);
      endcase
      r = $urandom_range(0, 99);
      if (r < 15) begin
         len = LEN_UNKNOWN;
      end else if (r < 85 && align != 16'd0) begin
         kmax = 32'hffff_ffff / {16'd0, align};
         if ($urandom_range(0, 99) < 70)
            k = $urandom_range(0, (kmax < 32'd4096) ? kmax : 32'd4096);
         else
            k = $urandom_range(0, kmax);
         len = k * {16'd0, align};
      end else begin
         len = $urandom;
      end
      make_header(ch, rate, align, bits, len);
      if ($urandom_range(0, 99) < 20) begin
         repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(0, 6))
               0: begin
                  case ($urandom_range(0, 3))
                     0: spot = 0;
                     1: spot = 8;
                     2: spot = 12;
                     default: spot = 36;
                  endcase
                  spot = spot + $urandom_range(0, 3);
                  hdr_image[spot] = hdr_image[spot] ^ (8'd1 << $urandom_range(0, 7));
               end
               1: put_word(16, FMT_SIZE_PCM ^ (32'd1 << $urandom_range(0, 31)));
               2: put_half(20, FORMAT_PCM ^ (16'd1 << $urandom_range(0, 15)));
               3: put_half(22, 16'd0);
               4: put_word(24, 32'd0);
               5: put_word(40, len ^ 32'd1);
               default: put_half(32, 16'd0);
            endcase
         end
      end
      if ($urandom_range(0, 99) < 10)
         queue_header($urandom_range(0, 43), 1'b1, $urandom_range(0, 49) == 0);
      else
         queue_header(44, 1'b0, $urandom_range(0, 49) == 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.header_byte <= '0;
         req_bus.stream_end  <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap != 0) begin
            send_gap = send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain &&
                       (req_bus.valid || expected_headers.size() != 0))) begin
            req_bus.valid <= 1'b0;
         end else begin
            next_req = pending_requests.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.header_byte <= next_req.header_byte;
            req_bus.stream_end  <= next_req.stream_end;
            send_gap = next_req.gap_after;
         end
      end
   end

   always @(posedge clock) begin
      bit                 done;
      header_summary_type predicted;
      header_summary_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
         rsp_burst_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_header_byte(req_bus.header_byte, req_bus.stream_end, done, predicted);
            if (done)
               expected_headers.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_headers.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0d",
                        $time, rsp_bus.status);
               fail_count++;
            end else begin
               want = expected_headers.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               check_field("channel_count", 32'(want.channel_count),
                           32'(rsp_bus.channel_count));
               check_field("rate_hz", want.rate_hz, rsp_bus.rate_hz);
               check_field("frame_bytes", 32'(want.frame_bytes), 32'(rsp_bus.frame_bytes));
               check_field("sample_bits", 32'(want.sample_bits), 32'(rsp_bus.sample_bits));
               check_field("payload_bytes", want.payload_bytes, rsp_bus.payload_bytes);
               check_field("frame_count", want.frame_count, rsp_bus.frame_count);
            end
            if (rsp_burst_left > 0) begin
               rsp_burst_left--;
               rsp_stall = 0;
            end else begin
               rsp_stall = draw_gap();
               if ($urandom_range(0, 9) == 0)
                  rsp_burst_left = $urandom_range(5, 20);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      fail_count    = 0;
      request_total = 0;
      burst_gaps    = 1'b0;
      clear_parser();

      // end marker in the idle state
      queue_request(8'hA5, 1'b1, 1'b0);
      make_header(16'd2, 32'd44100, 16'd4, 16'd16, 32'd4000);
      queue_header(44, 1'b0, 1'b0);
      // hold until drained, then a streaming length with zero alignment
      make_header(16'd1, 32'd8000, 16'd0, 16'd8, LEN_UNKNOWN);
      queue_header(44, 1'b0, 1'b1);
      make_header(16'd1, 32'd8000, 16'd0, 16'd8, 32'd100);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd2, 32'd48000, 16'd4, 16'd16, 32'd1002);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'hffff, 32'hffff_ffff, 16'hffff, 16'hffff, 32'hfffe_0001);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd1, 32'd1, 16'd1, 16'd0, 32'hffff_fffe);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd1, 32'd1, 16'd1, 16'd1, 32'd0);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd2, 32'd44100, 16'd4, 16'd16, 32'd400);
      hdr_image[0] = hdr_image[0] ^ 8'h01;
      queue_header(30, 1'b1, 1'b0);
      make_header(16'd2, 32'd44100, 16'd4, 16'd16, 32'd400);
      put_word(16, 32'd18);
      put_half(22, 16'd0);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd2, 32'd44100, 16'd8, 16'd32, 32'd800);
      put_half(20, 16'd3);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd0, 32'd44100, 16'd4, 16'd16, 32'd400);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd2, 32'd0, 16'd4, 16'd16, 32'd400);
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd2, 32'd22050, 16'd4, 16'd16, 32'd400);
      hdr_image[38] = 8'h00;
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd2, 32'd22050, 16'd4, 16'd16, 32'd400);
      hdr_image[9] = 8'hff;
      hdr_image[14] = 8'h00;
      queue_header(44, 1'b0, 1'b0);
      make_header(16'd6, 32'd96000, 16'd18, 16'd24, 32'd1800);
      queue_header(43, 1'b1, 1'b0);
      queue_request(8'h00, 1'b1, 1'b0);
      queue_request(8'hff, 1'b1, 1'b0);

      while (request_total < 1400) begin
         if ($urandom_range(0, 99) < 7) begin
            burst_gaps = 1'b0;
            repeat ($urandom_range(1, 50))
               queue_request(8'($urandom), $urandom_range(0, 9) == 0, 1'b0);
            if ($urandom_range(0, 4) != 0)
               queue_request(8'($urandom), 1'b1, 1'b0);
         end else begin
            queue_random_header();
         end
      end
      // drain before the last header
      make_header(16'd2, 32'd44100, 16'd4, 16'd16, 32'd4000);
      queue_header(44, 1'b0, 1'b1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (expected_headers.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
